// ----- src/rnlc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnlc_pkg
// Shared widths, the configuration bundle and the token that walks the
// label cell chain of the region neighbour label counter.
// ----------------------------------------------------------------------------
package rnlc_pkg;

  // label and position widths fixed by the interface
  localparam int LBL_W     = 6;
  localparam int CW        = 5;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int INC_W     = 2;
  localparam int MAX_ROWS  = 32;
  localparam int MAX_FRAME_COLS = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = CFG_IDX_W'(2);

  // configuration as seen by the front end
  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    logic [LBL_W-1:0] target;
  } cfg_t;

  // one token per accepted pixel: up to two candidate labels plus frame end
  typedef struct packed {
    logic             valid;
    logic             eof;
    logic             ma;
    logic [LBL_W-1:0] la;
    logic             mb;
    logic [LBL_W-1:0] lb;
    logic [INC_W-1:0] inc;
  } tok_t;

endpackage

// ----- src/region_neighbour_label_counter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_neighbour_label_counter_core
// Counts distinct labels 4-adjacent to a target region over a raster frame.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while not halted; the label cell chain
//   steps every cycle unless halted. The count appears on out_valid once
//   the frame's last pixel has passed one cell per label and the output register.
// The chain halts only while a result is held and the next frame end arrives.
// Reset clears position counters, seen bits, running count and output valid;
//   the line buffer is not cleared.
// ----------------------------------------------------------------------------
module region_neighbour_label_counter_core #(
  parameter int MAX_COLS    = 32,
  parameter int LABEL_COUNT = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rnlc_pkg::LBL_W-1:0]    in_pixel_label,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rnlc_pkg::LBL_W-1:0]    out_neighbour_count,
  input  logic                          cfg_we,
  input  logic [rnlc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rnlc_pkg::CFG_W-1:0]    cfg_data
);
  import rnlc_pkg::*;

  cfg_t             cfg_r;
  tok_t             chain [LABEL_COUNT+1];
  tok_t             last;
  logic             stall, adv, accept;
  logic [LBL_W-1:0] cnt_r, total;
  logic             out_valid_r;
  logic [LBL_W-1:0] out_cnt_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows   <= CFG_W'(1);
      cfg_r.cols   <= CFG_W'(1);
      cfg_r.target <= LBL_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ROWS:   cfg_r.rows   <= cfg_data;
        CFG_COLS:   cfg_r.cols   <= cfg_data;
        CFG_TARGET: cfg_r.target <= cfg_data;
        default: ;
      endcase
    end
  end

  // halt the chain only when a frame end meets a held result
  assign last     = chain[LABEL_COUNT];
  assign stall    = last.valid & last.eof & out_valid_r & out_stall;
  assign adv      = ~stall;
  assign in_stall = stall;
  assign accept   = in_valid & ~stall;

  rnlc_front #(
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .pix    (in_pixel_label),
    .cfg    (cfg_r),
    .tok    (chain[0])
  );

  // one cell per label
  for (genvar g = 0; g < LABEL_COUNT; g++) begin : g_cell
    rnlc_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  // accumulate new marks, emit on frame end
  assign total = cnt_r + LBL_W'(last.inc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv && last.valid) begin
        cnt_r <= last.eof ? '0 : total;
      end
      if (adv && last.valid && last.eof) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last.valid && last.eof) begin
      out_cnt_r <= total;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_neighbour_count = out_cnt_r;

endmodule

// ----- src/rnlc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnlc_front
// Raster position counters, line buffer of the row above and the left
// neighbour; forms the candidate-label token for every accepted pixel.
// ----------------------------------------------------------------------------
module rnlc_front #(
  parameter int MAX_COLS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [rnlc_pkg::LBL_W-1:0] pix,
  input  rnlc_pkg::cfg_t            cfg,
  output rnlc_pkg::tok_t            tok
);
  import rnlc_pkg::*;

  localparam int AW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int COL_LIM = (MAX_COLS < MAX_FRAME_COLS) ? MAX_COLS : MAX_FRAME_COLS;

  logic [CW-1:0]    row_r, row_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [LBL_W-1:0] left_r;
  logic [LBL_W-1:0] rd_r;
  logic [LBL_W-1:0] mem [MAX_COLS];

  logic [CFG_W-1:0] rows_eff, cols_eff;
  logic             col_last, row_last;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic             fwd;
  logic             pa_m, pb_m;
  logic [LBL_W-1:0] pa_l, pb_l;

  // clamp a column position into the line buffer
  function automatic logic [AW-1:0] col_addr(input logic [CW-1:0] c);
    if (int'(c) > MAX_COLS - 1) begin
      col_addr = AW'(MAX_COLS - 1);
    end else begin
      col_addr = AW'(c);
    end
  endfunction

  // effective frame size: zero acts as one, clamp to the largest frame
  always_comb begin
    rows_eff = cfg.rows;
    if (rows_eff == '0) rows_eff = CFG_W'(1);
    if (int'(rows_eff) > MAX_ROWS) rows_eff = CFG_W'(MAX_ROWS);
    cols_eff = cfg.cols;
    if (cols_eff == '0) cols_eff = CFG_W'(1);
    if (int'(cols_eff) > COL_LIM) cols_eff = CFG_W'(COL_LIM);
  end

  // advance raster position
  always_comb begin
    col_last = ({1'b0, col_r} + CFG_W'(1)) >= cols_eff;
    row_last = ({1'b0, row_r} + CFG_W'(1)) >= rows_eff;
    col_nxt  = col_r + CW'(1);
    row_nxt  = row_r;
    if (col_last) begin
      col_nxt = '0;
      row_nxt = row_last ? '0 : row_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      left_r <= '0;
    end else if (accept) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      left_r <= pix;
    end
  end

  // line buffer: prefetch the column of the next pixel, forward on collision
  assign wr_addr = col_addr(col_r);
  assign rd_addr = accept ? col_addr(col_nxt) : wr_addr;
  assign fwd     = accept && (rd_addr == wr_addr);

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wr_addr] <= pix;
    end
    rd_r <= fwd ? pix : mem[rd_addr];
  end

  // pick the non-target label of each neighbour pair
  always_comb begin
    pa_m = 1'b0;
    pa_l = pix;
    pb_m = 1'b0;
    pb_l = pix;
    if (row_r != '0) begin
      if (pix == cfg.target && rd_r != cfg.target) begin
        pa_m = 1'b1;
        pa_l = rd_r;
      end else if (rd_r == cfg.target && pix != cfg.target) begin
        pa_m = 1'b1;
        pa_l = pix;
      end
    end
    if (col_r != '0) begin
      if (pix == cfg.target && left_r != cfg.target) begin
        pb_m = 1'b1;
        pb_l = left_r;
      end else if (left_r == cfg.target && pix != cfg.target) begin
        pb_m = 1'b1;
        pb_l = pix;
      end
    end
  end

  // drop the second candidate when both name the same label
  always_comb begin
    tok.valid = accept;
    tok.eof   = col_last & row_last;
    tok.ma    = pa_m;
    tok.la    = pa_l;
    tok.mb    = pb_m & ~(pa_m & (pa_l == pb_l));
    tok.lb    = pb_l;
    tok.inc   = '0;
  end

endmodule

// ----- src/rnlc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnlc_cell
// One label of the seen bitmap. Marks its label when a passing token names
// it for the first time in the frame, and clears on the frame-end token.
// ----------------------------------------------------------------------------
module rnlc_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  rnlc_pkg::tok_t tok_i,
  output rnlc_pkg::tok_t tok_o
);
  import rnlc_pkg::*;

  logic seen_r, seen_nxt;
  logic hit, new_mark;
  tok_t tok_r, tok_nxt;

  // match this cell's label against both candidates
  always_comb begin
    hit      = tok_i.valid &
               ((tok_i.ma & (32'(tok_i.la) == CELL_IDX)) |
                (tok_i.mb & (32'(tok_i.lb) == CELL_IDX)));
    new_mark = hit & ~seen_r;
    seen_nxt = seen_r;
    if (tok_i.valid) begin
      seen_nxt = tok_i.eof ? 1'b0 : (seen_r | hit);
    end
    tok_nxt     = tok_i;
    tok_nxt.inc = tok_i.inc + INC_W'(new_mark);
  end

  // hold seen bit and token; only the seen bit and the token's valid bit are cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 1'b0;
      tok_r.valid <= 1'b0;
    end else if (adv) begin
      seen_r <= seen_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ----- src/rnlc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnlc_checker
// Port-level checks on the counter core: result hold, source of input
// stall, reset state and the bound on the reported count.
// ----------------------------------------------------------------------------
module rnlc_checker #(
  parameter int LABEL_COUNT = 64
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [rnlc_pkg::LBL_W-1:0] out_neighbour_count
);
  import rnlc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_neighbour_count))
    else $error("result changed while stalled");

  // input back-pressure comes only from a held result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // reset leaves no result and no stall
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall after reset");

  // no more distinct labels than the bitmap holds
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (LABEL_COUNT >= 64) || (int'(out_neighbour_count) <= LABEL_COUNT))
    else $error("neighbour count beyond label range");

  // a reported count is always a known value
  a_count_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_neighbour_count))
    else $error("unknown neighbour count on a valid result");

endmodule

bind region_neighbour_label_counter_core rnlc_checker #(
  .LABEL_COUNT(LABEL_COUNT)
) u_rnlc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_neighbour_count (out_neighbour_count)
);
